// ===== sv/msort_pkg.sv =====
// shared types and constants for the merge sorter block
// beat structs, cell control struct and the chain length
// no dependencies
package msort_pkg;

  localparam int unsigned MaxLen = 64;
  localparam int unsigned CountW = $clog2(MaxLen + 1);
  localparam int unsigned ValueW = 32;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } in_beat_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value_res;
    logic                     last_res;
    logic                     overflow;
  } out_beat_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     insert;
    logic                     shift;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== sv/msort_cell.sv =====
// one cell of the insertion chain: holds one value and its valid bit
// takes from its left neighbor or the new value on insert, from its right neighbor on shift
// depends on msort_pkg
module msort_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msort_pkg::cell_ctrl_t             ctrl_i,
  input  logic                              prev_take_i,
  input  logic                              prev_valid_i,
  input  logic signed [msort_pkg::ValueW-1:0] prev_value_i,
  input  logic                              next_valid_i,
  input  logic signed [msort_pkg::ValueW-1:0] next_value_i,
  output logic                              take_o,
  output logic                              valid_o,
  output logic signed [msort_pkg::ValueW-1:0] value_o
);
  import msort_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [ValueW-1:0] value_q, value_d;

  // empty cells act as +infinity, so the take flags stay monotonic
  assign take_o  = !valid_q || (ctrl_i.value < value_q);
  assign valid_o = valid_q;
  assign value_o = value_q;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.insert && take_o) begin
      if (prev_take_i) begin
        valid_d = prev_valid_i;
        value_d = prev_value_i;
      end else begin
        valid_d = 1'b1;
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== sv/merge_sorter_unit.sv =====
// top level of the merge sorter: a sorted chain of insertion cells
// plus fill/drain control and the output register
// depends on msort_pkg and msort_cell
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_beat_i) takes one value per
//   beat; the beat with last set closes the set. up to MaxLen (64) values
//   are kept, further ones are dropped and the set is flagged overflow
//   fill: one beat per cycle, each value is placed in order in the chain
//   in the same cycle, so the chain is always sorted
//   drain: after the closing beat drain_q is set, then the chain shifts toward
//   cell 0 and one sorted beat per cycle, while the receiver does not stall,
//   goes to the output register (out_valid_o / out_stall_i / out_beat_o);
//   last_res marks the final one
//   in_stall_o stays high while the set drains: it is drain_q, set by the
//   closing beat and cleared by the final pop
//   a stalled receiver freezes the output register and, while draining, the chain in place
//   reset empties the chain, clears the count and the overflow flag
module merge_sorter_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  msort_pkg::in_beat_t   in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output msort_pkg::out_beat_t  out_beat_o
);
  import msort_pkg::*;

  localparam logic [CountW-1:0] FullCount = CountW'(MaxLen);
  localparam logic [CountW-1:0] OneCount  = CountW'(1);

  // control registers
  logic [CountW-1:0] count_q, count_d;
  logic              drain_q, drain_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  // chain taps
  logic                     take   [MaxLen];
  logic                     valid  [MaxLen];
  logic signed [ValueW-1:0] value  [MaxLen];

  logic       in_acc, room, pop, out_free;
  cell_ctrl_t ctrl;

  assign in_acc   = in_valid_i && !drain_q;
  assign room     = count_q != FullCount;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = drain_q && out_free;

  assign ctrl.insert = in_acc && room;
  assign ctrl.shift  = pop;
  assign ctrl.value  = in_beat_i.value;

  // chain of cells, cell 0 holds the smallest value
  for (genvar i = 0; i < MaxLen; i++) begin : g_cell
    logic                     p_take, p_valid, n_valid;
    logic signed [ValueW-1:0] p_value, n_value;
    if (i == 0) begin : g_head
      assign p_take  = 1'b0;
      assign p_valid = 1'b0;
      assign p_value = '0;
    end else begin : g_mid
      assign p_take  = take[i-1];
      assign p_valid = valid[i-1];
      assign p_value = value[i-1];
    end
    if (i == MaxLen - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_body
      assign n_valid = valid[i+1];
      assign n_value = value[i+1];
    end
    msort_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_take_i  (p_take),
      .prev_valid_i (p_valid),
      .prev_value_i (p_value),
      .next_valid_i (n_valid),
      .next_value_i (n_value),
      .take_o       (take[i]),
      .valid_o      (valid[i]),
      .value_o      (value[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    drain_d     = drain_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // fill side
    if (in_acc) begin
      if (room) begin
        count_d = count_q + OneCount;
      end else begin
        ovf_d = 1'b1;
      end
      if (in_beat_i.last) begin
        drain_d = 1'b1;
      end
    end

    // output register empties when its beat is taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // drain side: move cell 0 into the output register
    if (pop) begin
      out_valid_d     = 1'b1;
      out_d.value_res = value[0];
      out_d.last_res  = (count_q == OneCount);
      out_d.overflow  = ovf_q;
      count_d         = count_q - OneCount;
      if (count_q == OneCount) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drain_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drain_q     <= drain_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = drain_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // a draining set always has a value at the head of the chain
  a_drain_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (count_q != '0) && valid[0])
    else $error("drain with empty chain");

  // the count never passes the chain length
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("element count out of range");

  // the chain stays sorted at its head while draining
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_q && valid[1]) |-> !(value[1] < value[0]))
    else $error("chain head out of order");

  // the final pop ends the drain and empties the count
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && count_q == OneCount) |=> (!drain_q && count_q == '0 && !ovf_q))
    else $error("drain did not close cleanly");

endmodule

// ===== dv/merge_sorter_checker.sv =====
// checker for the merge sorter: watches both beat channels, keeps its own
// ascending copy of the open set and compares every output beat in order
// depends on msort_pkg
module merge_sorter_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  msort_pkg::in_beat_t  in_beat_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  msort_pkg::out_beat_t out_beat_i,
  output int unsigned          fail_count_o,
  output int unsigned          due_count_o
);
  import msort_pkg::*;

  logic signed [ValueW-1:0] open_set_q[$];   // kept ascending
  logic                     set_dropped = 1'b0;
  out_beat_t                sorted_due_q[$];
  int unsigned              mismatches = 0;
  int unsigned              due_left = 0;

  assign fail_count_o = mismatches;
  assign due_count_o  = due_left;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    int unsigned pos;
    out_beat_t   due;
    if (rst_ni) begin
      // output side, oldest expectation first
      if (out_valid_i && !out_stall_i) begin
        if (sorted_due_q.size() == 0) begin
          report_mismatch($sformatf("beat with nothing due, value %0d",
                                    out_beat_i.value_res));
        end else begin
          due = sorted_due_q.pop_front();
          if (out_beat_i.value_res !== due.value_res)
            report_mismatch($sformatf("value_res %0d, due %0d",
                                      out_beat_i.value_res, due.value_res));
          if (out_beat_i.last_res !== due.last_res)
            report_mismatch($sformatf("last_res %b, due %b (value %0d)",
                                      out_beat_i.last_res, due.last_res, due.value_res));
          if (out_beat_i.overflow !== due.overflow)
            report_mismatch($sformatf("overflow %b, due %b (value %0d)",
                                      out_beat_i.overflow, due.overflow, due.value_res));
        end
      end
      // input side: place value in order, or drop it once the set is full
      if (in_valid_i && !in_stall_i) begin
        if (open_set_q.size() < MaxLen) begin
          pos = 0;
          while (pos < open_set_q.size() && open_set_q[pos] <= in_beat_i.value)
            pos++;
          open_set_q.insert(pos, in_beat_i.value);
        end else begin
          set_dropped = 1'b1;
        end
        if (in_beat_i.last) begin
          foreach (open_set_q[k])
            sorted_due_q.push_back('{value_res: open_set_q[k],
                                     last_res:  (k == open_set_q.size() - 1),
                                     overflow:  set_dropped});
          open_set_q.delete();
          set_dropped = 1'b0;
        end
      end
      due_left = sorted_due_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// top of the merge sorter testbench: clock, reset, beat stimulus with
// random gaps and stalls, watchdog and final verdict
// depends on msort_pkg, merge_sorter_unit and merge_sorter_checker
module testbench;
  import msort_pkg::*;

  typedef logic signed [ValueW-1:0] value_list_t[$];

  localparam int unsigned IdleLimit = 2000;   // cycles with no beat at all
  localparam int unsigned TailCycles = MaxLen + 16;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned idle_cycles = 0;
  int unsigned stall_hold = 0;
  bit          quiet_source = 1'b0;   // no gaps between input beats
  bit          quiet_sink = 1'b0;     // receiver stops stalling once its current hold runs out

  always #5 clk_i = ~clk_i;

  merge_sorter_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  merge_sorter_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_beat_i    (in_beat_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_beat_i   (out_beat_o),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  // mostly short idle runs, now and then a long one
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // full range most of the time, with small values for ties and the extremes
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      6, 7:    return $signed(ValueW'($urandom_range(0, 8))) - 4;
      8:       return {1'b1, {(ValueW-1){1'b0}}};
      9:       return {1'b0, {(ValueW-1){1'b1}}};
      default: return $signed(ValueW'($urandom()));
    endcase
  endfunction

  // receiver stall pattern: runs of ready, short stalls, a few long ones
  always @(posedge clk_i) begin
    int unsigned r;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (quiet_sink) begin
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall_i <= 1'b0;
        stall_hold  <= $urandom_range(0, 20);
      end else if (r < 93) begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(10, 40);
      end
    end
  end

  // watchdog: give up when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input beat, with an optional gap in front; returns right after the
  // edge at which it was accepted, so valid stays high into the next beat
  task automatic send_beat(input logic signed [ValueW-1:0] value, input logic last);
    int unsigned gap;
    gap = quiet_source ? 0 : pick_idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_beat_i.value <= value;
    in_beat_i.last  <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_set(input value_list_t values);
    foreach (values[i])
      send_beat(values[i], i == values.size() - 1);
  endtask

  // a set of random content with the given length
  task automatic send_random_set(input int unsigned len);
    value_list_t values;
    repeat (len) values.push_back(pick_value());
    send_set(values);
  endtask

  initial begin
    value_list_t values;
    int unsigned sent;
    int unsigned len;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: singletons at both extremes
    values = {32'sh7fff_ffff};
    send_set(values);
    values = {32'sh8000_0000};
    send_set(values);
    // extremes mixed with zero and the values next to it
    values = {32'sh0, 32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd1, 32'sh0};
    send_set(values);
    // ties, some on the closing beat
    values = {32'sd3, 32'sd3, -32'sd3, 32'sd3, 32'sd3};
    send_set(values);
    // alternating bit patterns, then a descending run
    values = {32'sh5555_5555, 32'shaaaa_aaaa};
    send_set(values);
    values = {32'sd8, 32'sd6, 32'sd5, 32'sd3, -32'sd2, -32'sd9};
    send_set(values);

    // random: mostly short sets, some streamed back to back, some without stalls
    sent = 0;
    while (sent < 30) begin
      quiet_source = ($urandom_range(0, 3) == 0);
      quiet_sink   <= ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      send_random_set(len);
      sent += len;
    end

    // capacity: store fills, the beat after it and the closing beat are dropped
    quiet_source = 1'b1;
    quiet_sink   <= 1'b0;
    send_random_set(MaxLen + 2);
    quiet_source = 1'b0;
    send_random_set(2);

    in_valid_i <= 1'b0;

    // drain every due beat, then watch for extras
    while (due_count != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (fail_count == 0 && due_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/msort_pkg.sv
sv/msort_cell.sv
sv/merge_sorter_unit.sv
dv/merge_sorter_checker.sv
dv/testbench.sv
